/* hw/rtl/serial_channel_mux_byte_stuffing_top_assert.svh */
// Assertion macros for the byte-stuffing mux RTL, included by scmbs_ser
`ifndef SERIAL_CHANNEL_MUX_BYTE_STUFFING_TOP_ASSERT_SVH
`define SERIAL_CHANNEL_MUX_BYTE_STUFFING_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SCMBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scmbs assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SCMBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scmbs assertion failed");

`endif

/* hw/rtl/scmbs_pkg.sv */
// Shared types, constants and helpers of the byte-stuffing serial mux
`default_nettype none

package scmbs_pkg;

    localparam int BYTE_W  = 8;
    localparam int CCNT_W  = 6;
    localparam int CIDX_W  = 3;
    localparam int MAX_RES = 3;
    localparam int RCNT_W  = 2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ESCAPE_BYTE   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_FORCE_ID_BYTE = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_FIRST_CH_ID   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_CHANNEL_COUNT = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_ESCAPE_XOR    = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_MUX_PORT      = 3'd5;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] RST_ESCAPE_BYTE   = 8'd192;
    localparam logic [BYTE_W-1:0] RST_FORCE_ID_BYTE = 8'd193;
    localparam logic [BYTE_W-1:0] RST_FIRST_CH_ID   = 8'd208;
    localparam logic [CCNT_W-1:0] RST_CHANNEL_COUNT = 6'd8;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_XOR    = 8'd32;
    localparam logic [BYTE_W-1:0] RST_MUX_PORT      = 8'd0;

    // Result kinds
    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    // Input modes
    localparam logic MODE_RX = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] force_id_byte;
        logic [BYTE_W-1:0] first_channel_id;
        logic [CCNT_W-1:0] channel_count;
        logic [BYTE_W-1:0] escape_xor;
        logic [BYTE_W-1:0] mux_port;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] dest;
        logic [BYTE_W-1:0] out_byte;
    } t_res;

    // All results of one request, entry 0 goes out first
    typedef struct packed {
        logic [RCNT_W-1:0]     cnt;
        t_res [MAX_RES-1:0]    res;
    } t_bundle;

    function automatic t_res mk_res(input logic k, input logic [BYTE_W-1:0] d,
                                    input logic [BYTE_W-1:0] b);
        t_res r;
        r.kind     = k;
        r.dest     = d;
        r.out_byte = b;
        return r;
    endfunction

    // Channel ID range test, upper bound computed without wrap
    function automatic logic is_chan(input logic [BYTE_W-1:0] v, input t_cfg c);
        logic [BYTE_W:0] hi;
        hi = {1'b0, c.first_channel_id} + {{(BYTE_W+1-CCNT_W){1'b0}}, c.channel_count};
        return (v >= c.first_channel_id) && ({1'b0, v} < hi);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/scmbs_if.sv */
// Request and result channel interfaces of the byte-stuffing serial mux
`default_nettype none

interface scmbs_in_if import scmbs_pkg::*;;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [BYTE_W-1:0] port;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, mode, port, data_byte, input ready);
    modport sink   (input valid, mode, port, data_byte, output ready);
endinterface

interface scmbs_out_if import scmbs_pkg::*;;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] dest;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, kind, dest, out_byte, last, input ready);
    modport sink   (input valid, kind, dest, out_byte, last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/scmbs_proc.sv */
// Input register, link state and single-pass decode of one request
`default_nettype none

module scmbs_proc import scmbs_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    scmbs_in_if.sink      i_req,
    output t_bundle       o_bnd,
    output logic          o_bnd_vld,
    input  wire logic     i_bnd_rdy
);

    // Input register
    logic              r_in_vld;
    logic              r_mode;
    logic [BYTE_W-1:0] r_port;
    logic [BYTE_W-1:0] r_data;

    // Link state
    logic [BYTE_W-1:0] r_rx_ch,    n_rx_ch;
    logic              r_rx_vld,   n_rx_vld;
    logic              r_esc_pend, n_esc_pend;
    logic [BYTE_W-1:0] r_tx_ch,    n_tx_ch;
    logic              r_tx_vld,   n_tx_vld;
    logic [BYTE_W-1:0] r_ltx_byte, n_ltx_byte;
    logic              r_ltx_esc,  n_ltx_esc;
    logic              r_ltx_vld,  n_ltx_vld;

    logic              adv;
    logic              data_is_ch;
    logic              port_is_ch;
    logic              new_id;
    logic              need_esc;
    logic [BYTE_W-1:0] rx_d;
    logic [BYTE_W-1:0] tx_x;
    t_bundle           bnd;

    assign adv         = r_in_vld && i_bnd_rdy;
    assign i_req.ready = !r_in_vld || i_bnd_rdy;
    assign o_bnd       = bnd;
    assign o_bnd_vld   = adv && (bnd.cnt != '0);

    // Input register: loads whenever the decode slot frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_mode <= i_req.mode;
            r_port <= i_req.port;
            r_data <= i_req.data_byte;
        end
    end

    assign data_is_ch = is_chan(r_data, i_cfg);
    assign port_is_ch = is_chan(r_port, i_cfg);
    assign new_id     = !r_tx_vld || (r_port != r_tx_ch);
    assign need_esc   = (r_data == i_cfg.escape_byte) || (r_data == i_cfg.force_id_byte) ||
                        data_is_ch;
    assign tx_x       = need_esc ? (r_data ^ i_cfg.escape_xor) : r_data;
    assign rx_d       = r_esc_pend ? (r_data ^ i_cfg.escape_xor) : r_data;

    // Decode: results of the held request and the next link state
    always_comb begin
        n_rx_ch    = r_rx_ch;
        n_rx_vld   = r_rx_vld;
        n_esc_pend = r_esc_pend;
        n_tx_ch    = r_tx_ch;
        n_tx_vld   = r_tx_vld;
        n_ltx_byte = r_ltx_byte;
        n_ltx_esc  = r_ltx_esc;
        n_ltx_vld  = r_ltx_vld;
        bnd        = '0;
        if (r_mode == MODE_RX) begin
            if (r_port == i_cfg.mux_port) begin
                if (r_data == i_cfg.escape_byte) begin
                    n_esc_pend = 1'b1;
                end else if (data_is_ch) begin
                    n_rx_ch  = r_data;
                    n_rx_vld = 1'b1;
                end else if ((r_data == i_cfg.force_id_byte) && r_ltx_vld) begin
                    // Peer asked for a resend of the channel ID and last byte
                    bnd.res[0] = mk_res(KIND_TX, i_cfg.mux_port, r_tx_ch);
                    if (r_ltx_esc) begin
                        bnd.res[1] = mk_res(KIND_TX, i_cfg.mux_port, i_cfg.escape_byte);
                        bnd.res[2] = mk_res(KIND_TX, i_cfg.mux_port, r_ltx_byte);
                        bnd.cnt    = 2'd3;
                    end else begin
                        bnd.res[1] = mk_res(KIND_TX, i_cfg.mux_port, r_ltx_byte);
                        bnd.cnt    = 2'd2;
                    end
                end else begin
                    n_esc_pend = 1'b0;
                    if (!r_rx_vld) begin
                        bnd.res[0] = mk_res(KIND_TX, i_cfg.mux_port, i_cfg.force_id_byte);
                    end else begin
                        bnd.res[0] = mk_res(KIND_DELIVER, r_rx_ch, rx_d);
                    end
                    bnd.cnt = 2'd1;
                end
            end else begin
                bnd.res[0] = mk_res(KIND_DELIVER, r_port, r_data);
                bnd.cnt    = 2'd1;
            end
        end else begin
            if (port_is_ch) begin
                // Optional channel ID, optional escape, then the byte
                case ({new_id, need_esc})
                    2'b11: begin
                        bnd.res[0] = mk_res(KIND_TX, i_cfg.mux_port, r_port);
                        bnd.res[1] = mk_res(KIND_TX, i_cfg.mux_port, i_cfg.escape_byte);
                        bnd.res[2] = mk_res(KIND_TX, i_cfg.mux_port, tx_x);
                        bnd.cnt    = 2'd3;
                    end
                    2'b10: begin
                        bnd.res[0] = mk_res(KIND_TX, i_cfg.mux_port, r_port);
                        bnd.res[1] = mk_res(KIND_TX, i_cfg.mux_port, tx_x);
                        bnd.cnt    = 2'd2;
                    end
                    2'b01: begin
                        bnd.res[0] = mk_res(KIND_TX, i_cfg.mux_port, i_cfg.escape_byte);
                        bnd.res[1] = mk_res(KIND_TX, i_cfg.mux_port, tx_x);
                        bnd.cnt    = 2'd2;
                    end
                    default: begin
                        bnd.res[0] = mk_res(KIND_TX, i_cfg.mux_port, tx_x);
                        bnd.cnt    = 2'd1;
                    end
                endcase
                n_ltx_byte = tx_x;
                n_ltx_esc  = need_esc;
                n_ltx_vld  = 1'b1;
                n_tx_ch    = r_port;
                n_tx_vld   = 1'b1;
            end else begin
                bnd.res[0] = mk_res(KIND_TX, r_port, r_data);
                bnd.cnt    = 2'd1;
            end
        end
    end

    // Link state commits when the request leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_ch    <= '0;
            r_rx_vld   <= 1'b0;
            r_esc_pend <= 1'b0;
            r_tx_ch    <= '0;
            r_tx_vld   <= 1'b0;
            r_ltx_byte <= '0;
            r_ltx_esc  <= 1'b0;
            r_ltx_vld  <= 1'b0;
        end else if (adv) begin
            r_rx_ch    <= n_rx_ch;
            r_rx_vld   <= n_rx_vld;
            r_esc_pend <= n_esc_pend;
            r_tx_ch    <= n_tx_ch;
            r_tx_vld   <= n_tx_vld;
            r_ltx_byte <= n_ltx_byte;
            r_ltx_esc  <= n_ltx_esc;
            r_ltx_vld  <= n_ltx_vld;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/scmbs_ser.sv */
// Result register: holds one request's results and hands them out in order
`default_nettype none

module scmbs_ser import scmbs_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_bundle  i_bnd,
    input  wire logic     i_bnd_vld,
    output logic          o_bnd_rdy,
    scmbs_out_if.source   o_res
);

    `include "serial_channel_mux_byte_stuffing_top_assert.svh"

    logic                  r_bvld;
    logic [RCNT_W-1:0]     r_idx;
    logic [RCNT_W-1:0]     r_cnt;
    t_res [MAX_RES-1:0]    r_res;

    logic                  is_last;
    logic                  take;
    t_res                  cur;

    assign cur       = r_res[r_idx];
    assign is_last   = (r_idx == RCNT_W'(r_cnt - 2'd1));
    assign take      = r_bvld && o_res.ready;
    assign o_bnd_rdy = !r_bvld || (o_res.ready && is_last);

    assign o_res.valid    = r_bvld;
    assign o_res.kind     = cur.kind;
    assign o_res.dest     = cur.dest;
    assign o_res.out_byte = cur.out_byte;
    assign o_res.last     = is_last;

    // Control: load a new set once the last result of the old one is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvld <= 1'b0;
            r_idx  <= '0;
            r_cnt  <= '0;
        end else if (o_bnd_rdy) begin
            r_bvld <= i_bnd_vld;
            r_idx  <= '0;
            if (i_bnd_vld) begin
                r_cnt <= i_bnd.cnt;
            end
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_bnd_rdy && i_bnd_vld) begin
            r_res <= i_bnd.res;
        end
    end

    `SCMBS_ASSERT_IMP(a_cnt_nonzero, i_clk, i_rst_n, r_bvld, r_cnt != '0)
    `SCMBS_ASSERT_IMP(a_idx_in_range, i_clk, i_rst_n, r_bvld, r_idx < r_cnt)
    `SCMBS_ASSERT_NXT(a_idx_steps, i_clk, i_rst_n, take && !is_last,
                      r_bvld && (r_idx == RCNT_W'($past(r_idx) + 2'd1)))

endmodule

`default_nettype wire

/* hw/rtl/serial_channel_mux_byte_stuffing_top.sv */
// Escaped byte-stuffing serial channel multiplexer, top level
//
// i_req carries one request per byte: mode 0 is a byte received on a port,
// mode 1 a byte to send to a port or a virtual channel ID. o_res carries the
// resulting bytes (transmit on a port, or deliver to a channel), zero to three
// per request, with last set on the final one. Both use valid/ready; a request
// or result moves when both are high.
// Configuration is a write port (i_cfg_we, i_cfg_idx, i_cfg_data) into six
// registers; write it only while no request is in flight.
// A request passes the input register, which loads at the accepting edge, and
// then the result register, which loads once it is free; its first result is
// on o_res once the result register has loaded.
// Throughput: one request per cycle while each yields one result and o_res does
// not stall; a request with more results holds the result register until o_res
// has moved them all, one byte per cycle. Requests that yield nothing skip it.
// Reset (synchronous, active low) loads the register defaults and clears the
// channel and escape state. When o_res stalls, the result register holds,
// one more request waits in the input register, and then i_req.ready drops.
`default_nettype none

module serial_channel_mux_byte_stuffing_top import scmbs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    scmbs_in_if.sink               i_req,
    scmbs_out_if.source            o_res,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_idx,
    input  wire logic [BYTE_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_bundle bnd;
    logic    bnd_vld;
    logic    bnd_rdy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.escape_byte      <= RST_ESCAPE_BYTE;
            r_cfg.force_id_byte    <= RST_FORCE_ID_BYTE;
            r_cfg.first_channel_id <= RST_FIRST_CH_ID;
            r_cfg.channel_count    <= RST_CHANNEL_COUNT;
            r_cfg.escape_xor       <= RST_ESCAPE_XOR;
            r_cfg.mux_port         <= RST_MUX_PORT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ESCAPE_BYTE:   r_cfg.escape_byte      <= i_cfg_data;
                CFG_FORCE_ID_BYTE: r_cfg.force_id_byte    <= i_cfg_data;
                CFG_FIRST_CH_ID:   r_cfg.first_channel_id <= i_cfg_data;
                CFG_CHANNEL_COUNT: r_cfg.channel_count    <= i_cfg_data[CCNT_W-1:0];
                CFG_ESCAPE_XOR:    r_cfg.escape_xor       <= i_cfg_data;
                CFG_MUX_PORT:      r_cfg.mux_port         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    scmbs_proc u_proc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_req     (i_req),
        .o_bnd     (bnd),
        .o_bnd_vld (bnd_vld),
        .i_bnd_rdy (bnd_rdy)
    );

    scmbs_ser u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bnd     (bnd),
        .i_bnd_vld (bnd_vld),
        .o_bnd_rdy (bnd_rdy),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

/* test/scmbs_checker.sv */
// Checker for the byte-stuffing serial mux: predicts link and delivery bytes, compares results
module scmbs_checker import scmbs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    scmbs_in_if                    i_req,
    scmbs_out_if                   i_res,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_idx,
    input  wire logic [BYTE_W-1:0] i_cfg_data,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] dest;
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_expect;

    // Bytes still owed by the block, oldest first
    t_expect due_bytes[$];

    // Shadow of the configuration registers
    logic [BYTE_W-1:0] esc_byte, force_byte, first_id, xor_mask, link_port;
    logic [CCNT_W-1:0] chan_count;

    // Shadow of the link state
    logic [BYTE_W-1:0] rx_chan, tx_chan, last_sent;
    logic              rx_sel, esc_seen, tx_sel, last_was_esc, last_sent_ok;

    // Channel ID test; upper bound kept at 9 bits so it does not wrap
    function automatic logic chan_id_hit(input logic [BYTE_W-1:0] v);
        logic [BYTE_W:0] top_id;
        top_id = {1'b0, first_id} + {{(BYTE_W + 1 - CCNT_W){1'b0}}, chan_count};
        return (v >= first_id) && ({1'b0, v} < top_id);
    endfunction

    function automatic t_expect link_byte(input logic [BYTE_W-1:0] b);
        return '{KIND_TX, link_port, b, 1'b0};
    endfunction

    // Work out the bytes one request causes and queue them
    task automatic predict_request(input logic mode, input logic [BYTE_W-1:0] port,
                                   input logic [BYTE_W-1:0] din);
        t_expect           burst[MAX_RES];
        int                n;
        logic [BYTE_W-1:0] d;
        n = 0;
        d = din;
        if (mode == MODE_RX) begin
            if (port == link_port) begin
                if (d == esc_byte) begin
                    esc_seen = 1'b1;
                end else if (chan_id_hit(d)) begin
                    rx_chan = d;
                    rx_sel  = 1'b1;
                end else if (d == force_byte && last_sent_ok) begin
                    // peer asks for the channel ID and last byte again
                    burst[n] = link_byte(tx_chan);
                    n++;
                    if (last_was_esc) begin
                        burst[n] = link_byte(esc_byte);
                        n++;
                    end
                    burst[n] = link_byte(last_sent);
                    n++;
                end else begin
                    if (esc_seen) begin
                        d        = d ^ xor_mask;
                        esc_seen = 1'b0;
                    end
                    if (!rx_sel) begin
                        burst[n] = link_byte(force_byte);
                    end else begin
                        burst[n] = '{KIND_DELIVER, rx_chan, d, 1'b0};
                    end
                    n++;
                end
            end else begin
                burst[n] = '{KIND_DELIVER, port, d, 1'b0};
                n++;
            end
        end else if (chan_id_hit(port)) begin
            // channel ID only on a change of channel
            if (!tx_sel || port != tx_chan) begin
                burst[n] = link_byte(port);
                n++;
            end
            if (d == esc_byte || d == force_byte || chan_id_hit(d)) begin
                burst[n] = link_byte(esc_byte);
                n++;
                burst[n] = link_byte(d ^ xor_mask);
                n++;
                last_sent    = d ^ xor_mask;
                last_was_esc = 1'b1;
            end else begin
                burst[n] = link_byte(d);
                n++;
                last_sent    = d;
                last_was_esc = 1'b0;
            end
            last_sent_ok = 1'b1;
            tx_chan      = port;
            tx_sel       = 1'b1;
        end else begin
            burst[n] = '{KIND_TX, port, d, 1'b0};
            n++;
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) begin
                burst[i].last = 1'b1;
            end
            due_bytes.push_back(burst[i]);
        end
    endtask

    // Sample both channels and the register port at each rising edge
    always @(posedge i_clk) begin
        t_expect got, want;
        if (!i_rst_n) begin
            esc_byte     = RST_ESCAPE_BYTE;
            force_byte   = RST_FORCE_ID_BYTE;
            first_id     = RST_FIRST_CH_ID;
            chan_count   = RST_CHANNEL_COUNT;
            xor_mask     = RST_ESCAPE_XOR;
            link_port    = RST_MUX_PORT;
            rx_chan      = '0;
            tx_chan      = '0;
            last_sent    = '0;
            rx_sel       = 1'b0;
            esc_seen     = 1'b0;
            tx_sel       = 1'b0;
            last_was_esc = 1'b0;
            last_sent_ok = 1'b0;
            due_bytes.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.kind, i_res.dest, i_res.out_byte, i_res.last};
                o_checked++;
                if (due_bytes.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("%t: unexpected result kind=%0d dest=%0d byte=%02h last=%0b",
                                 $realtime, got.kind, got.dest, got.out_byte, got.last);
                    end
                end else begin
                    want = due_bytes.pop_front();
                    if (got !== want) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("%t: mismatch expected kind=%0d dest=%0d byte=%02h last=%0b",
                                     $realtime, want.kind, want.dest, want.out_byte, want.last);
                            $display("%t:          got      kind=%0d dest=%0d byte=%02h last=%0b",
                                     $realtime, got.kind, got.dest, got.out_byte, got.last);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ESCAPE_BYTE:   esc_byte   = i_cfg_data;
                    CFG_FORCE_ID_BYTE: force_byte = i_cfg_data;
                    CFG_FIRST_CH_ID:   first_id   = i_cfg_data;
                    CFG_CHANNEL_COUNT: chan_count = i_cfg_data[CCNT_W-1:0];
                    CFG_ESCAPE_XOR:    xor_mask   = i_cfg_data;
                    CFG_MUX_PORT:      link_port  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                predict_request(i_req.mode, i_req.port, i_req.data_byte);
            end
        end
        o_pending = due_bytes.size();
    end

endmodule

/* test/tb_top.sv */
// Testbench top for the byte-stuffing serial mux: clock, reset, stimulus and verdict
module tb_top;
    import scmbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic              MODE_TX        = ~MODE_RX;
    localparam int                RAND_PER_PHASE = 80;
    localparam int                NUM_PHASES     = 6;
    localparam int                QUIET_LIMIT    = 5000;
    localparam logic [BYTE_W-1:0] LAST_CH        = RST_FIRST_CH_ID + 8'd7;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_idx;
    logic [BYTE_W-1:0] cfg_data;

    scmbs_in_if  req_if ();
    scmbs_out_if res_if ();

    int err_cnt, due_cnt, chk_cnt;
    int req_cnt;
    bit idle_en;

    // Current register values, used to aim the random requests
    logic [BYTE_W-1:0] st_esc, st_force, st_first, st_mux;
    logic [CCNT_W-1:0] st_count;

    serial_channel_mux_byte_stuffing_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    scmbs_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .i_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (err_cnt),
        .o_pending  (due_cnt),
        .o_checked  (chk_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result side: ready with random stall bursts
    initial begin
        int stall;
        forever begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 9);
                res_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    // Byte near one of the current special values, or anything at all
    function automatic logic [BYTE_W-1:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return st_esc;
            1:       return st_force;
            2, 3:    return st_first + 8'($urandom_range(0, int'(st_count) - 1));
            4:       return st_first - 8'd1;
            5:       return st_first + 8'(st_count);
            6:       return st_mux;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_chan();
        return st_first + 8'($urandom_range(0, int'(st_count) - 1));
    endfunction

    // One request, with an optional idle burst ahead of it
    task automatic send_req(input logic m, input logic [BYTE_W-1:0] p,
                            input logic [BYTE_W-1:0] d);
        int gap;
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.mode      <= m;
        req_if.port      <= p;
        req_if.data_byte <= d;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        req_cnt++;
    endtask

    // Hold off requests until every owed byte is back, then let the block settle
    task automatic drain_results();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (due_cnt != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
    endtask

    task automatic set_regs(input logic [BYTE_W-1:0] esc, input logic [BYTE_W-1:0] frc,
                            input logic [BYTE_W-1:0] first, input logic [CCNT_W-1:0] cnt,
                            input logic [BYTE_W-1:0] xmask, input logic [BYTE_W-1:0] mux);
        write_reg(CFG_ESCAPE_BYTE, esc);
        write_reg(CFG_FORCE_ID_BYTE, frc);
        write_reg(CFG_FIRST_CH_ID, first);
        write_reg(CFG_CHANNEL_COUNT, {{(BYTE_W - CCNT_W){1'b0}}, cnt});
        write_reg(CFG_ESCAPE_XOR, xmask);
        write_reg(CFG_MUX_PORT, mux);
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        st_esc   = esc;
        st_force = frc;
        st_first = first;
        st_count = cnt;
        st_mux   = mux;
    endtask

    // Main sequence
    initial begin
        logic              m;
        logic [BYTE_W-1:0] p;
        int                pause_at;
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        req_if.valid     = 1'b0;
        req_if.mode      = MODE_RX;
        req_if.port      = '0;
        req_if.data_byte = '0;
        res_if.ready     = 1'b0;
        idle_en          = 1'b1;
        req_cnt          = 0;
        st_esc           = RST_ESCAPE_BYTE;
        st_force         = RST_FORCE_ID_BYTE;
        st_first         = RST_FIRST_CH_ID;
        st_count         = RST_CHANNEL_COUNT;
        st_mux           = RST_MUX_PORT;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset register values
        send_req(MODE_RX, RST_MUX_PORT, 8'h41);               // no channel yet: force byte
        send_req(MODE_RX, RST_MUX_PORT, RST_FORCE_ID_BYTE);   // force before any send
        send_req(MODE_RX, RST_MUX_PORT, RST_FIRST_CH_ID);     // select lowest channel
        send_req(MODE_RX, RST_MUX_PORT, 8'h00);
        send_req(MODE_RX, RST_MUX_PORT, RST_ESCAPE_BYTE);
        send_req(MODE_RX, RST_MUX_PORT, RST_ESCAPE_BYTE ^ RST_ESCAPE_XOR);
        send_req(MODE_RX, 8'd7, 8'hFF);                        // other port passes through
        send_req(MODE_RX, 8'hFF, 8'h00);
        send_req(MODE_TX, LAST_CH, 8'h55);                     // new channel: ID then byte
        send_req(MODE_TX, LAST_CH, 8'hAA);                     // same channel: byte only
        send_req(MODE_TX, RST_FIRST_CH_ID, RST_ESCAPE_BYTE);   // escaped escape byte
        send_req(MODE_RX, RST_MUX_PORT, RST_FORCE_ID_BYTE);   // resend with escape
        send_req(MODE_TX, RST_FIRST_CH_ID, RST_FORCE_ID_BYTE);
        send_req(MODE_TX, RST_FIRST_CH_ID, RST_FIRST_CH_ID + 8'd2);
        send_req(MODE_TX, RST_FIRST_CH_ID + 8'd1, 8'h00);
        send_req(MODE_RX, RST_MUX_PORT, RST_FORCE_ID_BYTE);   // resend without escape
        send_req(MODE_TX, RST_MUX_PORT, 8'hFF);                // plain send on the link port
        send_req(MODE_TX, 8'hFF, RST_ESCAPE_BYTE);             // plain send, no stuffing
        send_req(MODE_RX, RST_MUX_PORT, LAST_CH);
        send_req(MODE_RX, RST_MUX_PORT, 8'hFF);
        send_req(MODE_RX, RST_MUX_PORT, RST_ESCAPE_BYTE);     // escape, then a channel ID
        send_req(MODE_RX, RST_MUX_PORT, RST_FIRST_CH_ID);
        send_req(MODE_RX, RST_MUX_PORT, RST_ESCAPE_XOR);      // unescapes to zero
        send_req(MODE_RX, RST_MUX_PORT, RST_FIRST_CH_ID - 8'd1);
        send_req(MODE_RX, RST_MUX_PORT, RST_FIRST_CH_ID + 8'd8);

        // Random requests under several register settings, phase 2 and the last one without idling
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            case (ph)
                0: set_regs(8'h7D, 8'h7E, 8'h80, 6'd1, 8'h20, 8'd3);
                1: set_regs(8'h00, 8'hFF, 8'hE0, 6'd32, 8'hFF, 8'hFF);
                2: set_regs(8'hFF, 8'h00, 8'hF0, 6'd32, 8'h00, 8'h00);
                // escape and force coincide, both inside the channel range
                3: set_regs(8'h10, 8'h10, 8'h08, 6'd16, 8'h01, 8'h01);
                4: set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 6'($urandom_range(1, 32)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: set_regs(RST_ESCAPE_BYTE, RST_FORCE_ID_BYTE, RST_FIRST_CH_ID,
                                  RST_CHANNEL_COUNT, RST_ESCAPE_XOR, RST_MUX_PORT);
            endcase
            idle_en  = (ph != 2) && (ph != NUM_PHASES - 1);
            pause_at = $urandom_range(5, RAND_PER_PHASE - 5);
            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                if (i == pause_at) begin
                    drain_results();
                end
                m = 1'($urandom_range(0, 1));
                if (m == MODE_RX) begin
                    p = ($urandom_range(0, 99) < 65) ? st_mux : pick_data();
                end else begin
                    p = ($urandom_range(0, 99) < 65) ? pick_chan() : pick_data();
                end
                send_req(m, p, pick_data());
            end
        end

        drain_results();
        repeat (12) @(negedge i_clk);

        $display("Ran %0d requests under %0d register settings, idle bursts on both sides;",
                 req_cnt, NUM_PHASES + 1);
        $display("%0d result bytes compared, %0d mismatches.", chk_cnt, err_cnt);
        if (err_cnt == 0 && due_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
